FILE: rtl/pss_pkg.sv
// Package for the pair sum search block: store geometry, payload structs,
// and the controller-to-datapath command and status structs. No dependencies.
package pss_pkg;

    localparam int MAX_ELEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ELEMS);
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
    localparam int IDX_W     = 10;

    typedef struct packed {
        logic [31:0] elem_value;
        logic        last_elem;
    } in_beat_t;

    typedef struct packed {
        logic             pair_found;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
        logic             overflowed;
    } out_beat_t;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_SORT_INI = 4'd2;  // i = 1, start outer pass
    localparam logic [3:0] OP_SORT_RD  = 4'd3;  // read cur = s[i]
    localparam logic [3:0] OP_SORT_RJ  = 4'd4;  // read s[j-1]
    localparam logic [3:0] OP_SORT_MV  = 4'd5;  // compare, shift or place
    localparam logic [3:0] OP_SRCH_INI = 4'd6;
    localparam logic [3:0] OP_SRCH_RI  = 4'd7;
    localparam logic [3:0] OP_SRCH_RM  = 4'd8;
    localparam logic [3:0] OP_SRCH_CMP = 4'd9;
    localparam logic [3:0] OP_SCAN_INI = 4'd10;
    localparam logic [3:0] OP_SCAN_RD  = 4'd11;
    localparam logic [3:0] OP_SCAN_CMP = 4'd12;
    localparam logic [3:0] OP_CLEAR    = 4'd13;

    typedef struct packed {
        logic [3:0] op;
    } pss_cmd_t;

    typedef struct packed {
        logic sort_done;   // outer index reached count
        logic move_stop;   // insertion slot found, cur placed
        logic srch_done;   // all i tried without success
        logic range_empty; // lo > hi for the current i
        logic hit;         // sum equals target
        logic scan_done;   // scan finished (found or exhausted)
        logic few;         // fewer than two elements held
    } pss_stat_t;

endpackage

FILE: rtl/pss_datapath.sv
// Datapath for the pair sum search block: both element stores, indexes,
// the 33-bit sum compare and the result register. Depends on pss_pkg.
module pss_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  pss_pkg::pss_cmd_t  cmd,
    input  logic [31:0]        elem_value,
    input  logic [31:0]        target_sum,
    output pss_pkg::pss_stat_t stat,
    output pss_pkg::out_beat_t result
);

    localparam int AW = pss_pkg::ADDR_W;
    localparam int CW = pss_pkg::CNT_W;

    logic [31:0] orig_mem [pss_pkg::MAX_ELEMS];
    logic [31:0] sort_mem [pss_pkg::MAX_ELEMS];

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] mid;
    logic [31:0]   cur_reg, cur_next;
    logic [31:0]   rd_reg;
    logic [31:0]   vi_reg, vi_next;
    logic [31:0]   pa_reg, pa_next, pb_reg, pb_next, other_reg, other_next;
    logic          have_reg, have_next;
    logic [CW-1:0] p_reg, p_next;
    logic          done_reg, done_next, found_reg, found_next;
    logic [CW-1:0] q_first_reg, q_first_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_data;
    logic [32:0]   sum;
    logic          sum_gt, sum_lt;

    assign mid    = CW'((lo_reg + hi_reg) >> 1);
    assign sum    = {vi_reg[31], vi_reg} + {rd_reg[31], rd_reg};
    assign sum_gt = $signed(sum) > $signed({target_sum[31], target_sum});
    assign sum_lt = $signed(sum) < $signed({target_sum[31], target_sum});

    // Read address per operation, into the sorted store or, for SCAN_RD, the arrival-order store; registered read.
    always_comb
    begin
        unique case (cmd.op)
            pss_pkg::OP_SORT_RD:  rd_addr = i_reg[AW-1:0];
            pss_pkg::OP_SORT_RJ:  rd_addr = AW'(j_reg - CW'(1));
            pss_pkg::OP_SRCH_RI:  rd_addr = i_reg[AW-1:0];
            pss_pkg::OP_SRCH_RM:  rd_addr = mid[AW-1:0];
            pss_pkg::OP_SCAN_RD:  rd_addr = p_reg[AW-1:0];
            default:              rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == pss_pkg::OP_SCAN_RD)
        begin
            rd_reg <= orig_mem[rd_addr];
        end
        else
        begin
            rd_reg <= sort_mem[rd_addr];
        end
        if (wr_en)
        begin
            sort_mem[wr_addr] <= wr_data;
        end
        if (cmd.op == pss_pkg::OP_LOAD && count_reg < CW'(pss_pkg::MAX_ELEMS))
        begin
            orig_mem[count_reg[AW-1:0]] <= elem_value;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        cur_next     = cur_reg;
        vi_next      = vi_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        other_next   = other_reg;
        have_next    = have_reg;
        p_next       = p_reg;
        done_next    = done_reg;
        found_next   = found_reg;
        q_first_next = q_first_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        wr_data      = elem_value;
        stat         = '0;
        stat.few     = count_reg < CW'(2);
        stat.sort_done = i_reg >= count_reg;
        stat.srch_done = (i_reg + CW'(1)) >= count_reg;
        stat.range_empty = lo_reg > hi_reg;
        stat.hit     = !sum_gt && !sum_lt;
        stat.scan_done = done_reg;
        stat.move_stop = (j_reg == '0) || !($signed(rd_reg) > $signed(cur_reg));
        unique case (cmd.op)
            pss_pkg::OP_LOAD:
            begin
                if (count_reg < CW'(pss_pkg::MAX_ELEMS))
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            pss_pkg::OP_SORT_INI:
            begin
                i_next = CW'(1);
            end
            pss_pkg::OP_SORT_RD:
            begin
                j_next = i_reg;
            end
            pss_pkg::OP_SORT_RJ:
            begin
                if (j_reg == '0)
                begin
                    // Nothing left to compare; the following SORT_MV places cur.
                    ;
                end
            end
            pss_pkg::OP_SORT_MV:
            begin
                // The first SORT_RJ of a pass latches cur from rd_reg, which then holds
                // s[i]; by the first move rd_reg holds s[j-1].
                wr_en = 1'b1;
                if (stat.move_stop)
                begin
                    wr_addr = j_reg[AW-1:0];
                    wr_data = cur_reg;
                    i_next  = i_reg + CW'(1);
                end
                else
                begin
                    wr_addr = j_reg[AW-1:0];
                    wr_data = rd_reg;
                    j_next  = j_reg - CW'(1);
                end
            end
            pss_pkg::OP_SRCH_INI:
            begin
                i_next = '0;
            end
            pss_pkg::OP_SRCH_RI:
            begin
                lo_next = (CW+1)'(i_reg) + (CW+1)'(1);
                hi_next = (CW+1)'(count_reg) - (CW+1)'(1);
            end
            pss_pkg::OP_SRCH_RM:
            begin
                if (lo_reg == (CW+1)'(i_reg) + (CW+1)'(1) &&
                    hi_reg == (CW+1)'(count_reg) - (CW+1)'(1) && !have_reg)
                begin
                    vi_next   = rd_reg;
                    have_next = 1'b1;
                end
            end
            pss_pkg::OP_SRCH_CMP:
            begin
                if (sum_gt)
                begin
                    hi_next = (CW+1)'(mid) - (CW+1)'(1);
                end
                else if (sum_lt)
                begin
                    lo_next = (CW+1)'(mid) + (CW+1)'(1);
                end
                else
                begin
                    pa_next = vi_reg;
                    pb_next = rd_reg;
                end
                if (sum_gt || sum_lt)
                begin
                    if (sum_gt ? ((CW+1)'(mid) - (CW+1)'(1) < lo_reg)
                               : ((CW+1)'(mid) + (CW+1)'(1) > hi_reg))
                    begin
                        i_next    = i_reg + CW'(1);
                        have_next = 1'b0;
                    end
                end
            end
            pss_pkg::OP_SCAN_INI:
            begin
                p_next     = '0;
                have_next  = 1'b0;
                done_next  = 1'b0;
                found_next = 1'b0;
            end
            pss_pkg::OP_SCAN_RD:
            begin
                ;
            end
            pss_pkg::OP_SCAN_CMP:
            begin
                if (!have_reg)
                begin
                    if (rd_reg == pa_reg || rd_reg == pb_reg)
                    begin
                        other_next   = (rd_reg == pa_reg) ? pb_reg : pa_reg;
                        have_next    = 1'b1;
                        q_first_next = p_reg;
                    end
                end
                else if (rd_reg == other_reg)
                begin
                    found_next = 1'b1;
                    done_next  = 1'b1;
                end
                if (!(have_reg && rd_reg == other_reg))
                begin
                    p_next = p_reg + CW'(1);
                    if (p_reg + CW'(1) >= count_reg)
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            pss_pkg::OP_CLEAR:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                have_next  = 1'b0;
                done_next  = 1'b0;
                found_next = 1'b0;
            end
            default:
            begin
                ;
            end
        endcase
    end

    // cur is captured from the read of s[i] the cycle after SORT_RD.
    always_ff @(posedge clk)
    begin
        if (cmd.op == pss_pkg::OP_SORT_RJ && j_reg == i_reg)
        begin
            cur_reg <= rd_reg;
        end
        else
        begin
            cur_reg <= cur_next;
        end
        vi_reg      <= vi_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        other_reg   <= other_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        j_reg       <= j_next;
        p_reg       <= p_next;
        q_first_reg <= q_first_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            have_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            have_reg  <= have_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    always_comb
    begin
        result.pair_found   = found_reg;
        result.first_index  = found_reg ? pss_pkg::IDX_W'(q_first_reg) : '0;
        result.second_index = found_reg ? pss_pkg::IDX_W'(p_reg) : '0;
        result.overflowed   = ovf_reg;
    end

endmodule

FILE: rtl/pss_ctrl.sv
// Controller state machine for the pair sum search block: input handshake,
// sort, search and scan sequencing, output register. Depends on pss_pkg.
module pss_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               last_elem,
    input  pss_pkg::pss_stat_t stat,
    input  pss_pkg::out_beat_t result,
    output pss_pkg::pss_cmd_t  cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output pss_pkg::out_beat_t out_data
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_SRD    = 4'd1;
    localparam logic [3:0] S_SCUR   = 4'd2;
    localparam logic [3:0] S_SRJ    = 4'd3;
    localparam logic [3:0] S_SMV    = 4'd4;
    localparam logic [3:0] S_FRI    = 4'd5;
    localparam logic [3:0] S_FWAIT  = 4'd6;
    localparam logic [3:0] S_FRM    = 4'd7;
    localparam logic [3:0] S_FCMP   = 4'd8;
    localparam logic [3:0] S_CRD    = 4'd9;
    localparam logic [3:0] S_CCMP   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;
    localparam logic [3:0] S_SORTI  = 4'd12;
    localparam logic [3:0] S_FMWAIT = 4'd13;
    localparam logic [3:0] S_CCHK   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    pss_pkg::out_beat_t out_reg, out_next;
    logic       in_fire;

    // The output register holds a finished result, so loading the next array
    // goes on while that result waits.
    assign in_ready  = (state_reg == S_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        cmd.op          = pss_pkg::OP_NONE;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    cmd.op = pss_pkg::OP_LOAD;
                    if (last_elem)
                    begin
                        state_next = S_SORTI;
                    end
                end
            end
            S_SORTI:
            begin
                if (stat.few)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = pss_pkg::OP_SORT_INI;
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                if (stat.sort_done)
                begin
                    cmd.op     = pss_pkg::OP_SRCH_INI;
                    state_next = S_FRI;
                end
                else
                begin
                    cmd.op     = pss_pkg::OP_SORT_RD;
                    state_next = S_SCUR;
                end
            end
            S_SCUR:
            begin
                cmd.op     = pss_pkg::OP_SORT_RJ;
                state_next = S_SMV;
            end
            S_SRJ:
            begin
                cmd.op     = pss_pkg::OP_SORT_RJ;
                state_next = S_SMV;
            end
            S_SMV:
            begin
                cmd.op     = pss_pkg::OP_SORT_MV;
                state_next = stat.move_stop ? S_SRD : S_SRJ;
            end
            S_FRI:
            begin
                if (stat.srch_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = pss_pkg::OP_SRCH_RI;
                    state_next = S_FWAIT;
                end
            end
            S_FWAIT:
            begin
                cmd.op     = pss_pkg::OP_SRCH_RM;
                state_next = S_FMWAIT;
            end
            S_FMWAIT:
            begin
                cmd.op     = pss_pkg::OP_SRCH_RM;
                state_next = S_FCMP;
            end
            S_FRM:
            begin
                // After a miss, either the range is still open (next probe) or
                // the datapath has advanced i and a new outer step begins.
                if (stat.range_empty)
                begin
                    state_next = S_FRI;
                end
                else
                begin
                    cmd.op     = pss_pkg::OP_SRCH_RM;
                    state_next = S_FCMP;
                end
            end
            S_FCMP:
            begin
                cmd.op = pss_pkg::OP_SRCH_CMP;
                if (stat.hit)
                begin
                    state_next = S_CRD;
                end
                else
                begin
                    state_next = S_FRM;
                end
            end
            S_CRD:
            begin
                cmd.op     = pss_pkg::OP_SCAN_INI;
                state_next = S_CCMP;
            end
            S_CCMP:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = pss_pkg::OP_SCAN_RD;
                    state_next = S_CCHK;
                end
            end
            S_CCHK:
            begin
                cmd.op     = pss_pkg::OP_SCAN_CMP;
                state_next = S_CCMP;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = result;
                    out_valid_next = 1'b1;
                    cmd.op         = pss_pkg::OP_CLEAR;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

FILE: rtl/pair_sum_search.sv
// Pair sum search top level: loads one element per beat, one beat per cycle
// while in_ready is high, then sorts a copy with insertion passes,
// binary-searches each position of the sorted copy and scans the arrival
// order; every step reads through the one read port shared by both stores.
// Reset (async, active low) clears counts, flags, the state machine and target_sum.
module pair_sum_search
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pss_pkg::in_beat_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pss_pkg::out_beat_t    out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           cfg_data
);

    // The target register is written whenever a configuration beat arrives.
    logic [31:0]        target_reg;
    pss_pkg::pss_cmd_t  cmd;
    pss_pkg::pss_stat_t stat;
    pss_pkg::out_beat_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_valid)
        begin
            target_reg <= cfg_data;
        end
    end

    pss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last_elem (in_data.last_elem),
        .stat      (stat),
        .result    (result),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    pss_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .elem_value (in_data.elem_value),
        .target_sum (target_reg),
        .stat       (stat),
        .result     (result)
    );

endmodule

FILE: tb/pair_sum_search_test.sv
// Self-checking testbench for pair_sum_search: loads arrays, predicts the pair
// search result and compares every result beat. Depends on rtl/pss_pkg.sv and pair_sum_search.
module pair_sum_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog limit in cycles without any accepted beat. A full store of
    // ascending values sorts in linear time; the overflow test loads such a store.
    localparam int STALL_LIMIT = 500000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    pss_pkg::in_beat_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    pss_pkg::out_beat_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [31:0] cfg_data = '0;

    // Predictor state: the elements held for the array being loaded, the drop
    // flag for that array, and the current target sum.
    logic [31:0] held_elems[$];
    logic        held_dropped = 1'b0;
    logic [31:0] target_copy = '0;
    pss_pkg::out_beat_t   pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int elems_sent = 0;
    int results_seen = 0;
    int pairs_seen = 0;
    int stall_cycles = 0;

    pair_sum_search dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Sort the held elements, binary-search each sorted position for its
    // partner with exact 64-bit sums, then locate the pair in arrival order.
    function automatic pss_pkg::out_beat_t predict_pair();
        longint    sorted_vals[$];
        longint    cur;
        longint    tgt;
        longint    sum;
        int        n;
        int        j;
        int        lo;
        int        hi;
        int        mid;
        int        p;
        logic [31:0] val_a;
        logic [31:0] val_b;
        logic [31:0] other;
        logic      hit;
        logic      have_first;
        pss_pkg::out_beat_t res;
        res = '0;
        res.overflowed = held_dropped;
        n = held_elems.size();
        hit = 1'b0;
        have_first = 1'b0;
        tgt = longint'($signed(target_copy));
        foreach (held_elems[k])
            sorted_vals = {sorted_vals, longint'($signed(held_elems[k]))};
        for (int i = 1; i < n; i++)
        begin
            cur = sorted_vals[i];
            j = i;
            while (j > 0 && sorted_vals[j-1] > cur)
            begin
                sorted_vals[j] = sorted_vals[j-1];
                j--;
            end
            sorted_vals[j] = cur;
        end
        for (int i = 0; i + 1 < n && !hit; i++)
        begin
            lo = i + 1;
            hi = n - 1;
            while (lo <= hi && !hit)
            begin
                mid = lo + (hi - lo) / 2;
                sum = sorted_vals[i] + sorted_vals[mid];
                if (sum > tgt)
                    hi = mid - 1;
                else if (sum < tgt)
                    lo = mid + 1;
                else
                begin
                    hit = 1'b1;
                    val_a = sorted_vals[i][31:0];
                    val_b = sorted_vals[mid][31:0];
                end
            end
        end
        if (!hit)
            return res;
        for (p = 0; p < n; p++)
        begin
            if (held_elems[p] == val_a || held_elems[p] == val_b)
            begin
                other = (held_elems[p] == val_a) ? val_b : val_a;
                have_first = 1'b1;
                break;
            end
        end
        if (have_first)
        begin
            for (int q = p + 1; q < n; q++)
            begin
                if (held_elems[q] == other)
                begin
                    res.pair_found = 1'b1;
                    res.first_index = p[pss_pkg::IDX_W-1:0];
                    res.second_index = q[pss_pkg::IDX_W-1:0];
                    break;
                end
            end
        end
        return res;
    endfunction

    // Sends one element beat, after idle cycles drawn one at a time, and
    // updates the predictor once the beat is accepted.
    task automatic send_elem(input logic [31:0] value, input logic is_last);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{elem_value: value, last_elem: is_last};
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
        elems_sent++;
        if (held_elems.size() < pss_pkg::MAX_ELEMS)
            held_elems = {held_elems, value};
        else
            held_dropped = 1'b1;
        if (is_last)
        begin
            pending_results = {pending_results, predict_pair()};
            held_elems.delete();
            held_dropped = 1'b0;
        end
    endtask

    // Writes target_sum once the block has drained every pending result.
    task automatic set_target(input logic [31:0] value);
        logic rdy;
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end
        while (!rdy);
        cfg_valid <= 1'b0;
        target_copy = value;
    endtask

    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        send_elem(a, 1'b0);
        send_elem(b, 1'b1);
    endtask

    // Directed corners: lone element, simple hit and miss, duplicates, the
    // register extremes, and sums that would wrap in 32 bits.
    task automatic test_directed();
        send_elem(32'd5, 1'b1);
        send_pair(32'd0, 32'd0);
        send_pair(32'd1, 32'd2);
        set_target(32'd10);
        send_elem(32'd5, 1'b0);
        send_elem(32'd3, 1'b0);
        send_elem(32'd5, 1'b0);
        send_elem(32'd7, 1'b1);
        set_target(32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF);
        set_target(32'h8000_0000);
        // The exact sum is +2^31, so this must not match even though it wraps.
        send_pair(32'h7FFF_FFFF, 32'd1);
        send_pair(32'h8000_0000, 32'd0);
        set_target(32'h7FFF_FFFF);
        send_pair(32'h8000_0000, 32'hFFFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'd0);
        set_target(32'hFFFF_FFFE);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fills the store with ascending values, then drops two more beats, the
    // last one included; the search runs over the held elements only.
    task automatic test_overflow();
        set_target(32'd2045);
        for (int i = 0; i < pss_pkg::MAX_ELEMS; i++)
            send_elem(32'(i * 2), 1'b0);
        send_elem(32'd1, 1'b0);
        send_elem(32'd2045, 1'b1);
        set_target(32'd0);
        send_pair(32'd4, 32'hFFFF_FFFC);
    endtask

    // Random arrays. Most carry a planted pair in random positions; the rest
    // are unplanted noise. Narrow-value arrays give duplicates and collisions.
    task automatic test_random(input int elem_budget);
        int          stop_at;
        int          len;
        int          pos_a;
        int          pos_b;
        int          arrays_done;
        logic        narrow;
        logic [31:0] vals[];
        stop_at = elems_sent + elem_budget;
        arrays_done = 0;
        narrow = 1'b0;
        while (elems_sent < stop_at)
        begin
            if (arrays_done % 30 == 0)
            begin
                narrow = $urandom_range(1);
                set_target(narrow ? 32'($signed($urandom_range(16)) - 8) : $urandom);
            end
            len = ($urandom_range(19) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
            vals = new[len];
            foreach (vals[k])
                vals[k] = narrow ? 32'($signed($urandom_range(16)) - 8) : $urandom;
            if (len > 1 && $urandom_range(9) != 0)
            begin
                pos_a = $urandom_range(len - 1);
                pos_b = $urandom_range(len - 1);
                if (pos_b == pos_a)
                    pos_b = (pos_a + 1) % len;
                vals[pos_b] = target_copy - vals[pos_a];
            end
            foreach (vals[k])
                send_elem(vals[k], k == len - 1);
            arrays_done++;
        end
    endtask

    // Result receiver with random backpressure.
    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Compares each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with none expected, got %p", $time, out_data);
                error_count++;
            end
            else
            begin
                if (out_data !== pending_results[0])
                begin
                    $display("%0t: result mismatch, expected %p, got %p",
                             $time, pending_results[0], out_data);
                    error_count++;
                end
                if (pending_results[0].pair_found)
                    pairs_seen++;
                void'(pending_results.pop_front());
            end
        end
    end

    // Watchdog: any accepted beat on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        send_idle_pct = 37;
        recv_idle_pct = 52;
        test_random(190);
        send_idle_pct = 52;
        recv_idle_pct = 37;
        test_random(190);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(190);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (50) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        $display("Loaded %0d elements and checked %0d search results, %0d with a pair.",
                 elems_sent, results_seen, pairs_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
